/* design/lsig_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsig_pkg
// Shared types and constants for the lat-long sphere index generator.
// ----------------------------------------------------------------------------
package lsig_pkg;

	localparam int MAX_RINGS    = 64;
	localparam int MAX_SEGMENTS = 128;

	localparam int RING_W = 7;   // ring_count register / ring position
	localparam int SEG_W  = 8;   // segment_count register (holds 128)
	localparam int POS_W  = 7;   // segment position 0..127
	localparam int IDX_W  = 14;  // vertex index

	localparam logic [RING_W-1:0] RING_MIN = RING_W'(1);
	localparam logic [RING_W-1:0] RING_MAX = RING_W'(MAX_RINGS);
	localparam logic [SEG_W-1:0]  SEG_MIN  = SEG_W'(3);
	localparam logic [SEG_W-1:0]  SEG_MAX  = SEG_W'(MAX_SEGMENTS);

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RING_COUNT      = 2'd0,
		CFG_SEGMENT_COUNT   = 2'd1,
		CFG_HEMISPHERE_ONLY = 2'd2,
		CFG_UNUSED          = 2'd3
	} cfg_idx_t;

	// walk section, one-hot
	typedef enum logic [3:0] {
		SEC_UPPER_BAND = 4'b0001,
		SEC_UPPER_CAP  = 4'b0010,
		SEC_LOWER_BAND = 4'b0100,
		SEC_LOWER_CAP  = 4'b1000
	} sec_t;

	// effective configuration seen by the walker
	typedef struct packed {
		logic [RING_W-1:0] rings;      // clamped to 1..MAX_RINGS
		logic [SEG_W-1:0]  segs;       // clamped to 3..MAX_SEGMENTS
		logic              hemi;
		logic              start_pend; // next triangle restarts the walk
	} walk_cfg_t;

	// one triangle
	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic             done;
	} tri_t;

endpackage
`default_nettype wire

/* design/lsig_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsig_cfg
// Configuration registers, count clamping and the pending walk restart.
// ----------------------------------------------------------------------------
module lsig_cfg import lsig_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [7:0]       cfg_data,
	input  wire logic             consume,
	output walk_cfg_t             wcfg
);

	logic [RING_W-1:0] ring_count_q;
	logic [SEG_W-1:0]  segment_count_q;
	logic              hemi_q;
	logic              start_pend_q;
	cfg_idx_t          idx;

	assign idx = cfg_idx_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= RING_MIN;
			segment_count_q <= SEG_MIN;
			hemi_q          <= 1'b0;
			start_pend_q    <= 1'b1;
		end else if (cfg_wr) begin
			case (idx)
				CFG_RING_COUNT: begin
					ring_count_q <= cfg_data[RING_W-1:0];
					start_pend_q <= 1'b1;
				end
				CFG_SEGMENT_COUNT: begin
					segment_count_q <= cfg_data[SEG_W-1:0];
					start_pend_q    <= 1'b1;
				end
				CFG_HEMISPHERE_ONLY: begin
					hemi_q       <= cfg_data[0];
					start_pend_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end else if (consume) begin
			start_pend_q <= 1'b0;
		end
	end

	always_comb begin
		wcfg = '0;
		if (ring_count_q < RING_MIN)      wcfg.rings = RING_MIN;
		else if (ring_count_q > RING_MAX) wcfg.rings = RING_MAX;
		else                              wcfg.rings = ring_count_q;
		if (segment_count_q < SEG_MIN)      wcfg.segs = SEG_MIN;
		else if (segment_count_q > SEG_MAX) wcfg.segs = SEG_MAX;
		else                                wcfg.segs = segment_count_q;
		wcfg.hemi       = hemi_q;
		wcfg.start_pend = start_pend_q;
	end

endmodule
`default_nettype wire

/* design/lsig_walk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsig_walk
// Walk state with running ring bases; forms one triangle and the next state.
// ----------------------------------------------------------------------------
module lsig_walk import lsig_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  walk_cfg_t  wcfg,
	input  wire logic  step,
	input  wire logic  restart,
	output tri_t       tri_o
);

	sec_t              sec_q, sec_e, sec_d;
	logic [RING_W-1:0] ring_q, ring_e, ring_d;
	logic [POS_W-1:0]  seg_q, seg_e, seg_d;
	logic              half_q, half_e, half_d;
	logic [IDX_W-1:0]  prev_q, prev_e, prev_d;  // base of the lower-numbered ring
	logic [IDX_W-1:0]  cur_q, cur_e, cur_d;     // base of the next ring, or the pole

	logic              go_start;
	logic              single_ring;
	logic [SEG_W-1:0]  i_inc;
	logic              last_seg;
	logic [POS_W-1:0]  n;
	logic [RING_W:0]   ring_inc;
	logic              last_ring;
	logic [IDX_W-1:0]  segs_w;
	logic [IDX_W-1:0]  p_i, p_n, c_i, c_n;

	assign single_ring = (wcfg.rings == RING_MIN);
	assign go_start    = restart | wcfg.start_pend;
	assign segs_w      = IDX_W'(wcfg.segs);

	// state as seen by this triangle, after any restart
	always_comb begin
		if (go_start) begin
			sec_e  = single_ring ? SEC_UPPER_CAP : SEC_UPPER_BAND;
			ring_e = RING_W'(1);
			seg_e  = '0;
			half_e = 1'b0;
			prev_e = '0;
			cur_e  = segs_w;
		end else begin
			sec_e  = sec_q;
			ring_e = ring_q;
			seg_e  = seg_q;
			half_e = half_q;
			prev_e = prev_q;
			cur_e  = cur_q;
		end
	end

	assign i_inc     = {1'b0, seg_e} + SEG_W'(1);
	assign last_seg  = (i_inc == wcfg.segs);
	assign n         = last_seg ? '0 : i_inc[POS_W-1:0];
	assign ring_inc  = {1'b0, ring_e} + (RING_W+1)'(1);
	assign last_ring = (ring_inc >= {1'b0, wcfg.rings});

	assign p_i = prev_e + IDX_W'(seg_e);
	assign p_n = prev_e + IDX_W'(n);
	assign c_i = cur_e + IDX_W'(seg_e);
	assign c_n = cur_e + IDX_W'(n);

	always_comb begin
		tri_o = '0;
		case (sec_e)
			SEC_UPPER_BAND: begin
				tri_o.a = p_i;
				tri_o.b = half_e ? c_n : p_n;
				tri_o.c = half_e ? c_i : c_n;
			end
			SEC_UPPER_CAP: begin
				tri_o.a    = p_i;
				tri_o.b    = p_n;
				tri_o.c    = cur_e;
				tri_o.done = wcfg.hemi & last_seg;
			end
			SEC_LOWER_BAND: begin
				tri_o.a = p_i;
				tri_o.b = half_e ? c_i : c_n;
				tri_o.c = half_e ? c_n : p_n;
			end
			SEC_LOWER_CAP: begin
				tri_o.a    = p_n;
				tri_o.b    = p_i;
				tri_o.c    = cur_e;
				tri_o.done = last_seg;
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		sec_d  = sec_e;
		ring_d = ring_e;
		seg_d  = seg_e;
		half_d = half_e;
		prev_d = prev_e;
		cur_d  = cur_e;
		if (tri_o.done) begin
			sec_d  = single_ring ? SEC_UPPER_CAP : SEC_UPPER_BAND;
			ring_d = RING_W'(1);
			seg_d  = '0;
			half_d = 1'b0;
			prev_d = '0;
			cur_d  = segs_w;
		end else begin
			case (sec_e)
				SEC_UPPER_BAND, SEC_LOWER_BAND: begin
					if (!half_e) begin
						half_d = 1'b1;
					end else begin
						half_d = 1'b0;
						seg_d  = i_inc[POS_W-1:0];
						if (last_seg) begin
							seg_d  = '0;
							ring_d = ring_inc[RING_W-1:0];
							prev_d = cur_e;
							cur_d  = cur_e + segs_w;
							if (last_ring) begin
								ring_d = RING_W'(1);
								sec_d  = (sec_e == SEC_UPPER_BAND) ? SEC_UPPER_CAP
								                                   : SEC_LOWER_CAP;
							end
						end
					end
				end
				SEC_UPPER_CAP: begin
					seg_d = i_inc[POS_W-1:0];
					if (last_seg) begin
						// lower half starts on the equator; its rings follow the pole
						sec_d  = single_ring ? SEC_LOWER_CAP : SEC_LOWER_BAND;
						ring_d = RING_W'(1);
						seg_d  = '0;
						half_d = 1'b0;
						prev_d = '0;
						cur_d  = cur_e + IDX_W'(1);
					end
				end
				default: begin
					seg_d = i_inc[POS_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_UPPER_BAND;
			ring_q <= RING_W'(1);
			seg_q  <= '0;
			half_q <= 1'b0;
			prev_q <= '0;
			cur_q  <= '0;
		end else if (step) begin
			sec_q  <= sec_d;
			ring_q <= ring_d;
			seg_q  <= seg_d;
			half_q <= half_d;
			prev_q <= prev_d;
			cur_q  <= cur_d;
		end
	end

endmodule
`default_nettype wire

/* design/latlong_sphere_index_generator_core.sv */
`default_nettype none
// An input transfer is registered in the input stage, then in the result stage once that is free.
// Throughput: one triangle per cycle while the result side is not stalled by m_tready.
// The output stage decouples the sides: a new input is taken while a result waits, if the input stage is empty.
// Reset (arst_n low, asynchronous): stages empty, ring_count 1, segment_count 3,
// full sphere, walk at the first triangle.
// ----------------------------------------------------------------------------
// latlong_sphere_index_generator_core
// Emits the vertex index triples of a latitude-longitude sphere, one per input.
// ----------------------------------------------------------------------------
module latlong_sphere_index_generator_core import lsig_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [13:0] vertex_a, [27:14] vertex_b,
	                                    // [41:28] vertex_c, [47:42] zero
	output logic             m_tlast,   // mesh_done
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic              s1_valid_q;
	logic              restart_s1;
	logic              out_valid_s2;
	tri_t              tri_s2;
	logic              adv;        // input stage moves into result stage
	logic              in_xfer;
	walk_cfg_t         wcfg;
	tri_t              tri_c;

	// config writes must arrive only while idle; the block does not enforce this and always takes them
	assign cfg_ready = 1'b1;

	assign adv      = s1_valid_q & (~out_valid_s2 | m_tready);
	assign s_tready = ~s1_valid_q | adv;
	assign in_xfer  = s_tvalid & s_tready;

	lsig_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.consume   (adv),
		.wcfg      (wcfg)
	);

	lsig_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.wcfg    (wcfg),
		.step    (adv),
		.restart (restart_s1),
		.tri_o   (tri_c)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			restart_s1 <= s_tdata[0];
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tri_s2 <= tri_c;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {6'd0, tri_s2.c, tri_s2.b, tri_s2.a};
	assign m_tlast  = tri_s2.done;

endmodule
`default_nettype wire

/* design/lsig_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsig_checker
// Port-level checks for the sphere index generator, bound to the top level.
// ----------------------------------------------------------------------------
module lsig_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata,
	input wire logic        m_tlast,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic [1:0]  cfg_index,
	input wire logic [7:0]  cfg_data
);

	// a stalled result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// a triangle never repeats a vertex
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] != m_tdata[27:14]) &&
		             (m_tdata[27:14] != m_tdata[41:28]) &&
		             (m_tdata[13:0] != m_tdata[41:28]))
		else $error("degenerate triangle");

	// indices stay inside the largest mesh
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] <= 14'd16257) && (m_tdata[27:14] <= 14'd16257) &&
		             (m_tdata[41:28] <= 14'd16257) && (m_tdata[47:42] == 6'd0))
		else $error("vertex index out of range");

	// a result shows up only after an input was taken
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready || (s_tvalid && s_tready), 2) ||
		                    $past(!s_tready, 1))
		else $error("result without input");

endmodule

bind latlong_sphere_index_generator_core lsig_checker u_lsig_checker (.*);
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the lat-long sphere index generator. A local walk predictor
// tracks the register settings and the triangle walk, one expected triangle
// per input transfer, and every output transfer is checked against the oldest
// pending one. A directed table covers reset state, wraps, restarts, clamped
// counts and the single ring caps; random walks under several register
// settings and three idle patterns follow.
// ----------------------------------------------------------------------------
module testbench;
	import lsig_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// ---------------------------------------------------------------- DUT I/O
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;  // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;            // [13:0] a, [27:14] b, [41:28] c, [47:42] zero
	logic        m_tlast;            // mesh_done
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_RING_COUNT;
	logic [7:0]  cfg_data  = 8'h00;

	latlong_sphere_index_generator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------- walk predictor
	// Register copies, written as the DUT takes config transfers.
	logic [RING_W-1:0] reg_rings = RING_W'(1);
	logic [SEG_W-1:0]  reg_segs  = SEG_W'(3);
	logic              reg_hemi  = 1'b0;

	// Walk position: section, band ring, segment, and which band triangle.
	sec_t walk_sec    = SEC_UPPER_BAND;
	int   walk_ring   = 1;
	int   walk_seg    = 0;
	bit   walk_second = 1'b0;

	tri_t pending_tris [$];   // expected triangles, oldest first
	int   mismatches = 0;
	int   cycles     = 0;

	// Stimulus side info: a typed-in expectation rides along with the transfer.
	bit   held_typed = 1'b0;
	tri_t held_want  = '0;

	int   sender_idle = 15;   // percent of cycles the sender holds off
	int   recv_idle   = 71;   // percent of cycles the receiver stalls

	function automatic int clamped_rings();
		if (reg_rings < RING_MIN) return 1;
		if (reg_rings > RING_MAX) return MAX_RINGS;
		return int'(reg_rings);
	endfunction

	function automatic int clamped_segs();
		if (reg_segs < SEG_MIN) return 3;
		if (reg_segs > SEG_MAX) return MAX_SEGMENTS;
		return int'(reg_segs);
	endfunction

	// A band section with no bands left (single ring) moves on to its cap.
	function automatic void skip_empty_bands();
		if ((walk_sec == SEC_UPPER_BAND || walk_sec == SEC_LOWER_BAND) &&
				walk_ring >= clamped_rings()) begin
			if (walk_sec == SEC_UPPER_BAND) walk_sec = SEC_UPPER_CAP;
			else walk_sec = SEC_LOWER_CAP;
			walk_ring   = 1;
			walk_seg    = 0;
			walk_second = 1'b0;
		end
	endfunction

	function automatic void rewind_walk();
		walk_sec    = SEC_UPPER_BAND;
		walk_ring   = 1;
		walk_seg    = 0;
		walk_second = 1'b0;
		skip_empty_bands();
	endfunction

	// Triangle for one input transfer; steps the walk on.
	function automatic tri_t next_triangle(input logic restart);
		int   rings, segs, lower_base, prev, cur, pole, i, n, a, b, c;
		logic last;
		tri_t t;
		rings      = clamped_rings();
		segs       = clamped_segs();
		lower_base = rings * segs + 1;   // first lower ring sits past the upper pole
		last       = 1'b0;
		if (restart) rewind_walk();
		i = walk_seg;
		n = (i + 1) % segs;
		case (walk_sec)
			SEC_UPPER_BAND: begin
				prev = (walk_ring - 1) * segs;
				cur  = walk_ring * segs;
				if (!walk_second) begin
					a = prev + i; b = prev + n; c = cur + n;
				end else begin
					a = prev + i; b = cur + n; c = cur + i;
				end
			end
			SEC_UPPER_CAP: begin
				prev = (rings - 1) * segs;
				a = prev + i; b = prev + n; c = prev + segs;
				last = reg_hemi && (i + 1 == segs);
			end
			SEC_LOWER_BAND: begin
				// the first lower band hangs off the shared equator, ring 0
				prev = (walk_ring == 1) ? 0 : (walk_ring - 2) * segs + lower_base;
				cur  = (walk_ring - 1) * segs + lower_base;
				if (!walk_second) begin
					a = prev + i; b = cur + n; c = prev + n;
				end else begin
					a = prev + i; b = cur + i; c = cur + n;
				end
			end
			default: begin
				// lower cap; one ring: equator, index past the upper pole
				if (rings > 1) begin
					prev = (rings - 2) * segs + lower_base;
					pole = prev + segs;
				end else begin
					prev = 0;
					pole = segs + 1;
				end
				a = prev + n; b = prev + i; c = pole;
				last = (i + 1 == segs);
			end
		endcase
		t.a    = IDX_W'(a);
		t.b    = IDX_W'(b);
		t.c    = IDX_W'(c);
		t.done = last;

		if (last) begin
			rewind_walk();
		end else if (walk_sec == SEC_UPPER_BAND || walk_sec == SEC_LOWER_BAND) begin
			if (!walk_second) begin
				walk_second = 1'b1;
			end else begin
				walk_second = 1'b0;
				walk_seg    = i + 1;
				if (walk_seg >= segs) begin
					walk_seg  = 0;
					walk_ring = walk_ring + 1;
					skip_empty_bands();
				end
			end
		end else begin
			walk_seg = i + 1;
			if (walk_seg >= segs) begin
				// upper cap of a full sphere done, go below the equator
				walk_sec    = SEC_LOWER_BAND;
				walk_ring   = 1;
				walk_seg    = 0;
				walk_second = 1'b0;
				skip_empty_bands();
			end
		end
		return t;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------- monitor
	// Samples all three channels at the edge; inputs change only by NBA there.
	always @(posedge clk) begin
		tri_t want;
		tri_t seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				// any listed register rewinds the walk; the spare index is ignored
				case (cfg_index)
					CFG_RING_COUNT: begin
						reg_rings = cfg_data[RING_W-1:0];
						rewind_walk();
					end
					CFG_SEGMENT_COUNT: begin
						reg_segs = cfg_data;
						rewind_walk();
					end
					CFG_HEMISPHERE_ONLY: begin
						reg_hemi = cfg_data[0];
						rewind_walk();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = next_triangle(s_tdata[0]);
				if (held_typed) want = held_want;
				pending_tris = {pending_tris, want};
			end
			if (m_tvalid && m_tready) begin
				seen.a    = m_tdata[IDX_W-1:0];
				seen.b    = m_tdata[2*IDX_W-1:IDX_W];
				seen.c    = m_tdata[3*IDX_W-1:2*IDX_W];
				seen.done = m_tlast;
				if (pending_tris.size() == 0) begin
					flag_error($sformatf("unexpected triangle a=%0d b=%0d c=%0d last=%0b",
						seen.a, seen.b, seen.c, seen.done));
				end else begin
					want = pending_tris.pop_front();
					if (seen !== want || m_tdata[47:3*IDX_W] !== '0) begin
						flag_error($sformatf(
							"triangle mismatch: want %0d %0d %0d last=%0b, got %0d %0d %0d last=%0b pad=%h",
							want.a, want.b, want.c, want.done,
							seen.a, seen.b, seen.c, seen.done, m_tdata[47:3*IDX_W]));
					end
				end
			end
		end
	end

	// Receiver: random stalls at the current rate.
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle);

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL latlong_sphere_index_generator_core");
			$finish;
		end
	end

	// ------------------------------------------------------------- drivers
	// Each task returns in the step of its transfer edge; the next call drives
	// the channels in that same step, so every signal sees one NBA per step.
	task automatic send_item(input logic restart, input bit typed, input tri_t want);
		cfg_valid <= 1'b0;
		while ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tdata    <= {7'b0, restart};
		held_typed <= typed;
		held_want  <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Stop sending and hold until every expected triangle is out.
	task automatic wait_drained();
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (pending_tris.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------ directed table
	typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef struct {
		row_kind_t  kind;
		cfg_idx_t   idx;      // register for a config row
		logic [7:0] value;    // its write data
		logic       restart;
		bit         typed;    // expected triangle typed in below
		int         wa, wb, wc;
		bit         wlast;
	} row_t;

	localparam int PLAN_ROWS = 34;
	row_t plan [PLAN_ROWS];

	initial begin
		tri_t row_want;
		int   burst, pause_at;

		plan = '{
			// reset: one ring, three segments, full sphere -> caps only
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 3, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 1, 2, 3, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 2, 0, 3, 1'b0},
			// lower cap on the equator, pole skips the upper one
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 1, 0, 4, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 2, 1, 4, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 2, 4, 1'b1},
			// wrap, then restart
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 3, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b1, 1'b1, 0, 1, 3, 1'b0},
			// hemisphere only: upper cap ends the mesh
			'{ROW_CFG, CFG_HEMISPHERE_ONLY, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 3, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 1, 2, 3, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 2, 0, 3, 1'b1},
			// segment count below three, two rings: first band
			'{ROW_CFG, CFG_SEGMENT_COUNT, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_RING_COUNT, 8'h02, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 4, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 4, 3, 1'b0},
			// spare index must not disturb the walk
			'{ROW_CFG, CFG_UNUSED, 8'h5A, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			// counts above the maximum clamp to 64 x 128
			'{ROW_CFG, CFG_RING_COUNT, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_SEGMENT_COUNT, 8'hFF, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_HEMISPHERE_ONLY, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 129, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 129, 128, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b1, 1'b1, 0, 1, 129, 1'b0},
			// ring count masked to zero acts as one, 128 segments
			'{ROW_CFG, CFG_RING_COUNT, 8'h80, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_SEGMENT_COUNT, 8'h80, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b1, 0, 1, 128, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			// 64 rings of three
			'{ROW_CFG, CFG_SEGMENT_COUNT, 8'h02, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_RING_COUNT, 8'h40, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b1, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_CFG, CFG_HEMISPHERE_ONLY, 8'h01, 1'b0, 1'b0, 0, 0, 0, 1'b0},
			'{ROW_ITEM, CFG_UNUSED, 8'h00, 1'b0, 1'b0, 0, 0, 0, 1'b0}
		};

		rewind_walk();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows; registers change only once the pipe has drained.
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				wait_drained();
				repeat (3) @(posedge clk);
				write_reg(plan[r].idx, plan[r].value);
			end else begin
				row_want.a    = IDX_W'(plan[r].wa);
				row_want.b    = IDX_W'(plan[r].wb);
				row_want.c    = IDX_W'(plan[r].wc);
				row_want.done = plan[r].wlast;
				send_item(plan[r].restart, plan[r].typed, row_want);
			end
		end

		// Random walks: three idle patterns, six register settings each.
		// Mostly small meshes so full walks with wraps come around often.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin sender_idle = 15; recv_idle = 71; end
				1: begin sender_idle = 71; recv_idle = 15; end
				default: begin sender_idle = 0; recv_idle = 0; end
			endcase
			for (int epoch = 0; epoch < 6; epoch++) begin
				wait_drained();
				repeat (3) @(posedge clk);
				write_reg(CFG_RING_COUNT, ($urandom_range(7) == 0) ?
					8'($urandom) : 8'($urandom_range(4)));
				write_reg(CFG_SEGMENT_COUNT, ($urandom_range(7) == 0) ?
					8'($urandom) : 8'($urandom_range(7)));
				write_reg(CFG_HEMISPHERE_ONLY, 8'($urandom));
				if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, 8'($urandom));
				burst    = $urandom_range(25, 55);
				pause_at = ((phase == 0 && epoch == 1) || $urandom_range(3) == 0) ?
					burst / 2 : -1;
				for (int k = 0; k < burst; k++) begin
					// hold-off: let the output side run dry mid-walk
					if (k == pause_at) wait_drained();
					send_item($urandom_range(31) == 0, 1'b0, '0);
				end
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_tris.size() == 0) begin
			$display("PASS latlong_sphere_index_generator_core");
		end else begin
			$display("FAIL latlong_sphere_index_generator_core");
		end
		$finish;
	end

endmodule
